@@ src/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked after reset
`define AFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked after reset
`define AFC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/afc_pkg.sv @@
// shared constants and types for the animation frame controller
package afc_pkg;

  // working width of the frame datapath, wide enough for wraps and mirrors
  localparam int FW        = 40;
  localparam int SPAN_W    = 33;
  localparam int PROD_W    = 48;
  localparam int MAX_WRAPS = 8;
  localparam int WRAP_W    = $clog2(MAX_WRAPS + 1);

  localparam logic signed [FW-1:0] EPS_LSB = FW'(66);
  localparam logic signed [FW-1:0] ONE_LSB = FW'(65536);

  localparam logic [2:0] MODE_CLAMP    = 3'd0;
  localparam logic [2:0] MODE_RESET    = 3'd1;
  localparam logic [2:0] MODE_LOOP     = 3'd2;
  localparam logic [2:0] MODE_REVERSE  = 3'd3;
  localparam logic [2:0] MODE_PINGPONG = 3'd4;

  localparam logic [1:0] CFG_END_MODE    = 2'd0;
  localparam logic [1:0] CFG_START_FRAME = 2'd1;
  localparam logic [1:0] CFG_END_FRAME   = 2'd2;
  localparam logic [1:0] CFG_LOOP_FRAME  = 2'd3;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef struct packed {
    logic signed [FW-1:0] a;
    logic signed [FW-1:0] b;
    logic                 sub;
  } alu_req_t;

  typedef struct packed {
    logic signed [FW-1:0] sum;
    logic                 neg;
  } alu_res_t;

endpackage

@@ src/afc_in_if.sv @@
// input channel: tick or load word
interface afc_in_if;
  import afc_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] load_frame;
  logic signed [31:0] load_rate;
  logic [15:0]        scale;

  modport source (output valid, func, load_frame, load_rate, scale, input ready);
  modport sink   (input valid, func, load_frame, load_rate, scale, output ready);
endinterface

@@ src/afc_out_if.sv @@
// result channel: frame, rate and flags
interface afc_out_if;
  import afc_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [31:0] frame_now;
  logic signed [31:0] rate_now;
  logic               ended;
  logic               looped;

  modport source (output valid, frame_now, rate_now, ended, looped, input ready);
  modport sink   (input valid, frame_now, rate_now, ended, looped, output ready);
endinterface

@@ src/afc_cfg_if.sv @@
// configuration write channel
interface afc_cfg_if;
  import afc_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [31:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

@@ src/afc_alu.sv @@
// shared add/subtract unit with sign flag for compares
module afc_alu (
  input  afc_pkg::alu_req_t req,
  output afc_pkg::alu_res_t res
);
  import afc_pkg::*;

  logic signed [FW-1:0] b_op;
  logic signed [FW-1:0] sum;

  // two's complement subtract through inverted operand and carry in
  assign b_op = req.sub ? ~req.b : req.b;
  assign sum  = req.a + b_op + FW'(req.sub);

  assign res.sum = sum;
  assign res.neg = sum[FW-1];
endmodule

@@ src/animation_frame_controller.sv @@
// animation frame controller top level: sequencer around one shared adder
// a load goes straight to the result; a tick multiplies, advances, then per end mode:
// clamp/reset bound, reverse/ping-pong mirror, loop wraps up to MAX_WRAPS, others done
// the next word is accepted in the cycle after the result is registered
// frame adds, subtracts and bound compares of a tick go through the single shared adder
// synchronous active-low reset clears the config registers, frame and rate to zero
`include "assert_macros.svh"

module animation_frame_controller (
  input  logic           clk,
  input  logic           rst_n,
  afc_in_if.sink         in_ch,
  afc_out_if.source      out_ch,
  afc_cfg_if.sink        cfg_ch
);
  import afc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_ADV,
    S_CLP_LO, S_CLP_HI, S_CLP_END,
    S_BOUND, S_MIR_HI_CMP, S_MIR_HI, S_MIR_LO_CMP, S_MIR_LO,
    S_SPAN_UP, S_SPAN_DN, S_WRAP_LO, S_ADD_UP, S_WRAP_HI, S_SUB_DN,
    S_DONE
  } state_t;

  state_t state_r;

  logic [2:0]          end_mode_r;
  logic signed [31:0]  start_frame_r;
  logic signed [31:0]  end_frame_r;
  logic signed [31:0]  loop_frame_r;
  logic signed [31:0]  frame_pos_r;
  logic signed [31:0]  frame_rate_r;

  logic [15:0]         scale_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [FW-1:0]     f_r;
  logic signed [31:0]       r_r;
  logic                     end_flag_r;
  logic                     loop_flag_r;
  logic signed [SPAN_W-1:0] up_r;
  logic signed [SPAN_W-1:0] dn_r;
  logic signed [SPAN_W-1:0] bound_r;
  logic [WRAP_W-1:0]        wraps_r;

  logic                out_valid_r;
  logic signed [31:0]  out_frame_r;
  logic signed [31:0]  out_rate_r;
  logic                out_ended_r;
  logic                out_looped_r;

  logic signed [PROD_W:0] mul_full;
  alu_req_t alu_req;
  alu_res_t alu_res;
  logic     in_fire;
  logic     out_free;
  logic     wrap_cap;

  function automatic logic signed [FW-1:0] ext32(input logic signed [31:0] v);
    return {{(FW-32){v[31]}}, v};
  endfunction

  function automatic logic signed [FW-1:0] ext33(input logic signed [SPAN_W-1:0] v);
    return {{(FW-SPAN_W){v[SPAN_W-1]}}, v};
  endfunction

  // negating the most negative rate saturates
  function automatic logic signed [31:0] neg_rate(input logic signed [31:0] v);
    logic signed [31:0] n;
    n = -v;
    if (v == {1'b1, {31{1'b0}}}) begin
      n = {1'b0, {31{1'b1}}};
    end
    return n;
  endfunction

  function automatic logic signed [31:0] sat_frame(input logic signed [FW-1:0] v);
    logic signed [31:0] s;
    s = v[31:0];
    if (!((&v[FW-1:31]) || !(|v[FW-1:31]))) begin
      s = v[FW-1] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
    end
    return s;
  endfunction

  afc_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign wrap_cap     = (wraps_r == WRAP_W'(MAX_WRAPS));

  assign mul_full = frame_rate_r * $signed({1'b0, scale_r});

  assign out_ch.valid     = out_valid_r;
  assign out_ch.frame_now = out_frame_r;
  assign out_ch.rate_now  = out_rate_r;
  assign out_ch.ended     = out_ended_r;
  assign out_ch.looped    = out_looped_r;

  // operand select for the shared adder
  always_comb begin
    alu_req.a   = f_r;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    unique case (state_r) inside
      S_ADV: begin
        alu_req.a = ext32(frame_pos_r);
        alu_req.b = {{(FW-(PROD_W-12)){prod_r[PROD_W-1]}}, prod_r[PROD_W-1:12]};
      end
      S_BOUND: begin
        alu_req.a   = ext32(end_frame_r);
        alu_req.b   = (end_mode_r == MODE_PINGPONG) ? ONE_LSB : '0;
        alu_req.sub = 1'b1;
      end
      S_CLP_LO, S_MIR_LO_CMP, S_WRAP_LO: begin
        alu_req.b   = ext32(start_frame_r);
        alu_req.sub = 1'b1;
      end
      S_CLP_HI, S_WRAP_HI: begin
        alu_req.b   = ext32(end_frame_r);
        alu_req.sub = 1'b1;
      end
      S_CLP_END: begin
        alu_req.a   = ext32(end_frame_r);
        alu_req.b   = EPS_LSB;
        alu_req.sub = 1'b1;
      end
      S_MIR_HI_CMP: begin
        alu_req.b   = ext33(bound_r);
        alu_req.sub = 1'b1;
      end
      S_MIR_HI: begin
        alu_req.a   = ext33(bound_r) <<< 1;
        alu_req.b   = f_r;
        alu_req.sub = 1'b1;
      end
      S_MIR_LO: begin
        alu_req.a   = ext32(start_frame_r) <<< 1;
        alu_req.b   = f_r;
        alu_req.sub = 1'b1;
      end
      S_SPAN_UP: begin
        alu_req.a   = ext32(loop_frame_r);
        alu_req.b   = ext32(start_frame_r);
        alu_req.sub = 1'b1;
      end
      S_SPAN_DN: begin
        alu_req.a   = ext32(end_frame_r);
        alu_req.b   = ext32(loop_frame_r);
        alu_req.sub = 1'b1;
      end
      S_ADD_UP: begin
        alu_req.b = ext33(up_r);
      end
      S_SUB_DN: begin
        alu_req.b   = ext33(dn_r);
        alu_req.sub = 1'b1;
      end
      S_IDLE, S_MUL, S_DONE: begin
        alu_req.b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      end_mode_r    <= MODE_CLAMP;
      start_frame_r <= '0;
      end_frame_r   <= '0;
      loop_frame_r  <= '0;
      frame_pos_r   <= '0;
      frame_rate_r  <= '0;
      wraps_r       <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.addr)
          CFG_END_MODE:    end_mode_r    <= cfg_ch.data[2:0];
          CFG_START_FRAME: start_frame_r <= cfg_ch.data;
          CFG_END_FRAME:   end_frame_r   <= cfg_ch.data;
          CFG_LOOP_FRAME:  loop_frame_r  <= cfg_ch.data;
        endcase
      end

      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            end_flag_r  <= 1'b0;
            loop_flag_r <= 1'b0;
            wraps_r     <= '0;
            if (in_ch.func == FUNC_LOAD) begin
              f_r     <= ext32(in_ch.load_frame);
              r_r     <= in_ch.load_rate;
              state_r <= S_DONE;
            end else begin
              scale_r <= in_ch.scale;
              r_r     <= frame_rate_r;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_r  <= mul_full[PROD_W-1:0];
          state_r <= S_ADV;
        end
        S_ADV: begin
          f_r <= alu_res.sum;
          case (end_mode_r) inside
            MODE_CLAMP, MODE_RESET:     state_r <= S_CLP_LO;
            MODE_LOOP:                  state_r <= S_SPAN_UP;
            MODE_REVERSE, MODE_PINGPONG: state_r <= S_BOUND;
            default:                    state_r <= S_DONE;
          endcase
        end
        S_CLP_LO: begin
          if (alu_res.neg) begin
            f_r        <= ext32(start_frame_r);
            r_r        <= '0;
            end_flag_r <= 1'b1;
          end
          state_r <= S_CLP_HI;
        end
        S_CLP_HI: begin
          state_r <= S_DONE;
          if (!alu_res.neg) begin
            if (end_mode_r == MODE_CLAMP) begin
              state_r <= S_CLP_END;
            end else begin
              f_r        <= ext32(start_frame_r);
              r_r        <= '0;
              end_flag_r <= 1'b1;
            end
          end
        end
        S_CLP_END: begin
          f_r        <= alu_res.sum;
          r_r        <= '0;
          end_flag_r <= 1'b1;
          state_r    <= S_DONE;
        end
        S_BOUND: begin
          bound_r <= alu_res.sum[SPAN_W-1:0];
          state_r <= S_MIR_HI_CMP;
        end
        S_MIR_HI_CMP: begin
          state_r <= alu_res.neg ? S_MIR_LO_CMP : S_MIR_HI;
        end
        S_MIR_HI: begin
          f_r     <= alu_res.sum;
          r_r     <= neg_rate(r_r);
          state_r <= S_MIR_LO_CMP;
        end
        S_MIR_LO_CMP: begin
          state_r <= alu_res.neg ? S_MIR_LO : S_DONE;
        end
        S_MIR_LO: begin
          f_r <= alu_res.sum;
          if (end_mode_r == MODE_REVERSE) begin
            r_r        <= '0;
            end_flag_r <= 1'b1;
          end else begin
            r_r         <= neg_rate(r_r);
            loop_flag_r <= 1'b1;
          end
          state_r <= S_DONE;
        end
        S_SPAN_UP: begin
          up_r    <= alu_res.sum[SPAN_W-1:0];
          state_r <= S_SPAN_DN;
        end
        S_SPAN_DN: begin
          dn_r    <= alu_res.sum[SPAN_W-1:0];
          state_r <= S_WRAP_LO;
        end
        S_WRAP_LO: begin
          state_r <= S_WRAP_HI;
          if (alu_res.neg) begin
            loop_flag_r <= 1'b1;
            // a span of zero or less never wraps
            if (!(up_r[SPAN_W-1] || up_r == '0 || wrap_cap)) begin
              state_r <= S_ADD_UP;
            end
          end
        end
        S_ADD_UP: begin
          f_r     <= alu_res.sum;
          wraps_r <= wraps_r + 1'b1;
          state_r <= S_WRAP_LO;
        end
        S_WRAP_HI: begin
          state_r <= S_DONE;
          if (!alu_res.neg) begin
            loop_flag_r <= 1'b1;
            if (!(dn_r[SPAN_W-1] || dn_r == '0 || wrap_cap)) begin
              state_r <= S_SUB_DN;
            end
          end
        end
        S_SUB_DN: begin
          f_r     <= alu_res.sum;
          wraps_r <= wraps_r + 1'b1;
          state_r <= S_WRAP_HI;
        end
        S_DONE: begin
          if (out_free) begin
            frame_pos_r  <= sat_frame(f_r);
            frame_rate_r <= r_r;
            out_frame_r  <= sat_frame(f_r);
            out_rate_r   <= r_r;
            out_ended_r  <= end_flag_r;
            out_looped_r <= loop_flag_r;
            state_r      <= S_IDLE;
          end
        end
      endcase
    end
  end

  `AFC_ASSERT_IMP(a_wrap_cap, 1'b1, wraps_r <= WRAP_W'(MAX_WRAPS), "wrap count past cap")
  `AFC_ASSERT_IMP(a_flags_excl, out_valid_r, !(out_ended_r && out_looped_r), "both flags set")
  `AFC_ASSERT_NXT(a_load_done, in_fire && in_ch.func == FUNC_LOAD, state_r == S_DONE,
    "load word did not go straight to result")

endmodule

@@ verif/animation_frame_controller_test.sv @@
// self-checking testbench for the animation frame controller: directed plan, then random phases
module animation_frame_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import afc_pkg::*;

  localparam logic [2:0] MODE_SPARE   = 3'd5;
  localparam int         RANDOM_ITEMS = 720;
  localparam int         HOLD_AT      = 300;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         QUIET_LIMIT  = 4000;
  localparam int         DRAIN_CYCLES = 40;
  localparam longint     INT_HI       = 64'sd2147483647;
  localparam longint     INT_LO       = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] frame;
    logic signed [31:0] rate;
    logic               ended;
    logic               looped;
  } frame_word_t;

  typedef struct packed {
    bit          is_reg;
    logic [1:0]  addr;
    logic [31:0] data;
    logic        func;
    logic [31:0] frame;
    logic [31:0] rate;
    logic [15:0] scale;
    bit          typed;
    frame_word_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  afc_in_if  in_ch();
  afc_out_if out_ch();
  afc_cfg_if cfg_ch();

  animation_frame_controller u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // mirror of the registers and the counter state
  logic [2:0]         cfg_mode;
  logic signed [31:0] cfg_start;
  logic signed [31:0] cfg_end;
  logic signed [31:0] cfg_loop;
  logic signed [31:0] model_pos;
  logic signed [31:0] model_rate;

  frame_word_t frames_due[$];
  frame_word_t due_word;
  plan_row_t   plan[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint flip_rate(input longint r);
    return (r == INT_LO) ? INT_HI : -r;
  endfunction

  // advances the mirrored counter by one word and returns the word it should produce
  function automatic frame_word_t next_frame_state(input logic func, input logic [31:0] ld_frame,
                                                   input logic [31:0] ld_rate,
                                                   input logic [15:0] scale);
    frame_word_t res;
    longint      prod, f, r, lo, hi, lp, up, down, turn;
    int          wraps;
    res = '0;
    if (func == FUNC_LOAD) begin
      model_pos  = ld_frame;
      model_rate = ld_rate;
    end else begin
      prod = longint'(model_rate) * longint'({48'd0, scale});
      // arithmetic shift floors toward minus infinity
      f  = longint'(model_pos) + (prod >>> 12);
      r  = longint'(model_rate);
      lo = cfg_start;
      hi = cfg_end;
      lp = cfg_loop;
      case (cfg_mode)
        MODE_CLAMP: begin
          if (f < lo) begin
            f = lo; r = 0; res.ended = 1'b1;
          end
          if (f >= hi) begin
            f = hi - EPS_LSB; r = 0; res.ended = 1'b1;
          end
        end
        MODE_RESET: begin
          if (f < lo || f >= hi) begin
            f = lo; r = 0; res.ended = 1'b1;
          end
        end
        MODE_LOOP: begin
          up    = lp - lo;
          down  = hi - lp;
          wraps = 0;
          while (f < lo) begin
            res.looped = 1'b1;
            if (up <= 0 || wraps >= MAX_WRAPS) break;
            f += up;
            wraps++;
          end
          while (f >= hi) begin
            res.looped = 1'b1;
            if (down <= 0 || wraps >= MAX_WRAPS) break;
            f -= down;
            wraps++;
          end
        end
        MODE_REVERSE: begin
          if (f >= hi) begin
            f = 2 * hi - f; r = flip_rate(r);
          end
          if (f < lo) begin
            f = 2 * lo - f; r = 0; res.ended = 1'b1;
          end
        end
        MODE_PINGPONG: begin
          turn = hi - ONE_LSB;
          if (f >= turn) begin
            f = 2 * turn - f; r = flip_rate(r);
          end
          if (f < lo) begin
            f = 2 * lo - f; r = flip_rate(r); res.looped = 1'b1;
          end
        end
        default: ;
      endcase
      if (f > INT_HI) f = INT_HI;
      else if (f < INT_LO) f = INT_LO;
      model_pos  = 32'(f);
      model_rate = 32'(r);
    end
    res.frame = model_pos;
    res.rate  = model_rate;
    return res;
  endfunction

  function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [31:0] value);
    plan_row_t row;
    row        = '0;
    row.is_reg = 1'b1;
    row.addr   = idx;
    row.data   = value;
    return row;
  endfunction

  // a load simply echoes what it loads
  function automatic plan_row_t load_row(input logic [31:0] fr, input logic [31:0] rt,
                                         input logic [15:0] sc);
    plan_row_t row;
    row       = '0;
    row.func  = FUNC_LOAD;
    row.frame = fr;
    row.rate  = rt;
    row.scale = sc;
    row.typed = 1'b1;
    row.want  = {fr, rt, 1'b0, 1'b0};
    return row;
  endfunction

  function automatic plan_row_t tick_row(input logic [15:0] sc);
    plan_row_t row;
    row       = '0;
    row.func  = FUNC_TICK;
    row.scale = sc;
    return row;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at result %0d, %s: got %h expected %h", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic send_word(input logic func, input logic [31:0] fr, input logic [31:0] rt,
                           input logic [15:0] sc, input bit typed, input frame_word_t want);
    int          gap;
    frame_word_t pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.load_frame <= fr;
    in_ch.load_rate  <= rt;
    in_ch.scale      <= sc;
    do @(posedge clk); while (!in_ch.ready);
    pred = next_frame_state(func, fr, rt, sc);
    frames_due.push_back(typed ? want : pred);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_END_MODE:    cfg_mode  = value[2:0];
      CFG_START_FRAME: cfg_start = value;
      CFG_END_FRAME:   cfg_end   = value;
      CFG_LOOP_FRAME:  cfg_loop  = value;
      default: ;
    endcase
  endtask

  // registers only change with the block idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic new_setting();
    int          kind;
    longint      base, span;
    logic [31:0] s, e, l, mode_word;
    logic [2:0]  m;
    kind = $urandom_range(0, 9);
    m = ($urandom_range(0, 7) != 0) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
    if (kind == 0) begin
      s = 32'h8000_0000; e = 32'h7FFF_FFFF; l = $urandom();
    end else if (kind == 1) begin
      s = $urandom(); e = $urandom(); l = $urandom();
    end else if (kind == 2) begin
      s = $urandom(); e = s; l = s;
    end else begin
      base = longint'($urandom_range(0, 32'h0800_0000)) - 64'sh0400_0000;
      span = longint'($urandom_range(32'h0001_0000, 32'h00C8_0000));
      s = 32'(base);
      e = 32'(base + span);
      l = ($urandom_range(0, 9) == 0) ? s : 32'(base + longint'($urandom_range(0, 32'(span))));
      if ($urandom_range(0, 15) == 0) l = $urandom();
    end
    // upper bits of the mode word are don't-care
    mode_word      = $urandom();
    mode_word[2:0] = m;
    settle();
    write_reg(CFG_END_MODE, mode_word);
    write_reg(CFG_START_FRAME, s);
    write_reg(CFG_END_FRAME, e);
    write_reg(CFG_LOOP_FRAME, l);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] frame_in_range();
    longint   lo, span;
    bit [63:0] raw;
    lo   = cfg_start;
    span = longint'(cfg_end) - lo;
    if (span <= 0) return $urandom();
    raw = {$urandom(), $urandom()};
    return 32'(lo + longint'(raw[62:0]) % span);
  endfunction

  task automatic send_random_item();
    int          pick;
    logic        func;
    logic [31:0] fr, rt;
    logic [15:0] sc;
    pick = $urandom_range(0, 99);
    fr   = $urandom();
    rt   = $urandom();
    sc   = 16'($urandom());
    func = FUNC_TICK;
    if (pick < 12) begin
      func = FUNC_LOAD;
      fr   = frame_in_range();
      rt   = 32'($urandom_range(0, 32'h0018_0000)) - 32'h000C_0000;
    end else if (pick < 15) begin
      func = FUNC_LOAD;
    end else begin
      case ($urandom_range(0, 9)) inside
        0: sc = 16'h0000;
        1: sc = 16'hFFFF;
        2, 3: ;
        default: sc = 16'(32'h0E00 + $urandom_range(0, 32'h0400));
      endcase
    end
    send_word(func, fr, rt, sc, 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (frames_due.size() == 0) begin
        note_mismatch("result with nothing pending", out_ch.frame_now, '0);
      end else begin
        due_word = frames_due.pop_front();
        if (out_ch.frame_now !== due_word.frame)
          note_mismatch("frame_now", out_ch.frame_now, due_word.frame);
        if (out_ch.rate_now !== due_word.rate)
          note_mismatch("rate_now", out_ch.rate_now, due_word.rate);
        if (out_ch.ended !== due_word.ended)
          note_mismatch("ended", {31'd0, out_ch.ended}, {31'd0, due_word.ended});
        if (out_ch.looped !== due_word.looped)
          note_mismatch("looped", {31'd0, out_ch.looped}, {31'd0, due_word.looped});
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : receiver
    int run, style;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      // one long hold-off so the block backs up into its input
      if (hold_go && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      style = $urandom_range(0, 3);
      run   = $urandom_range(4, 40);
      repeat (run) begin
        case (style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 9) > 6);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int sent, n;
    bit reg_open;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_TICK;
    in_ch.load_frame <= '0;
    in_ch.load_rate  <= '0;
    in_ch.scale      <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.addr      <= CFG_END_MODE;
    cfg_ch.data      <= '0;
    cfg_mode   = MODE_CLAMP;
    cfg_start  = '0;
    cfg_end    = '0;
    cfg_loop   = '0;
    model_pos  = '0;
    model_rate = '0;
    reg_open   = 1'b0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // first tick straight out of reset: empty range, so it clamps below zero
    plan.push_back(tick_row(16'h1000));
    plan[0].typed = 1'b1;
    plan[0].want  = {32'hFFFF_FFBE, 32'h0000_0000, 1'b1, 1'b0};
    plan.push_back(load_row(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
    plan.push_back(load_row(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000));
    // range 0 .. 100 frames, loop point at 10
    plan.push_back(reg_row(CFG_END_MODE, {29'd0, MODE_CLAMP}));
    plan.push_back(reg_row(CFG_START_FRAME, 32'h0000_0000));
    plan.push_back(reg_row(CFG_END_FRAME, 32'h0064_0000));
    plan.push_back(reg_row(CFG_LOOP_FRAME, 32'h000A_0000));
    plan.push_back(load_row(32'h0005_0000, 32'h0001_0000, 16'h0000));
    plan.push_back(tick_row(16'hFFFF));
    plan.push_back(load_row(32'h0063_0000, 32'h0002_0000, 16'h0000));
    plan.push_back(tick_row(16'h1000));
    plan.push_back(load_row(32'h0001_0000, 32'hFFFE_0000, 16'h0000));
    plan.push_back(tick_row(16'h1000));
    plan.push_back(reg_row(CFG_END_MODE, {29'd0, MODE_RESET}));
    plan.push_back(load_row(32'h0063_0000, 32'h0002_0000, 16'h0000));
    plan.push_back(tick_row(16'h1000));
    plan.push_back(reg_row(CFG_END_MODE, {29'd0, MODE_LOOP}));
    plan.push_back(load_row(32'h005F_0000, 32'h000A_0000, 16'h0000));
    plan.push_back(tick_row(16'h1000));
    plan.push_back(load_row(32'h0005_0000, 32'hFFF6_0000, 16'h0000));
    plan.push_back(tick_row(16'h1000));
    // wrap cap: the step is far larger than eight spans
    plan.push_back(load_row(32'h0000_0000, 32'h7FFF_FFFF, 16'h0000));
    plan.push_back(tick_row(16'hFFFF));
    plan.push_back(reg_row(CFG_END_MODE, {29'd0, MODE_REVERSE}));
    plan.push_back(load_row(32'h0063_0000, 32'h0002_0000, 16'h0000));
    plan.push_back(tick_row(16'h1000));
    plan.push_back(load_row(32'h0001_0000, 32'hFFFE_0000, 16'h0000));
    plan.push_back(tick_row(16'h1000));
    plan.push_back(reg_row(CFG_END_MODE, {29'd0, MODE_PINGPONG}));
    plan.push_back(load_row(32'h0062_8000, 32'h0001_0000, 16'h0000));
    plan.push_back(tick_row(16'h1000));
    // most negative rate bounces off the start and saturates on negation
    plan.push_back(load_row(32'h0000_0000, 32'h8000_0000, 16'h0000));
    plan.push_back(tick_row(16'h0001));
    plan.push_back(reg_row(CFG_END_MODE, {29'd0, MODE_SPARE}));
    plan.push_back(load_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000));
    plan.push_back(tick_row(16'hFFFF));

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!reg_open) begin
          settle();
          reg_open = 1'b1;
        end
        write_reg(plan[i].addr, plan[i].data);
      end else begin
        if (reg_open) begin
          cfg_ch.valid <= 1'b0;
          reg_open = 1'b0;
        end
        send_word(plan[i].func, plan[i].frame, plan[i].rate, plan[i].scale,
                  plan[i].typed, plan[i].want);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      new_setting();
      n = $urandom_range(20, 60);
      repeat (n) begin
        if (sent == HOLD_AT) hold_go = 1'b1;
        send_random_item();
        sent++;
      end
    end

    in_ch.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/afc_pkg.sv
src/afc_in_if.sv
src/afc_out_if.sv
src/afc_cfg_if.sv
src/afc_alu.sv
src/animation_frame_controller.sv
verif/animation_frame_controller_test.sv
